@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Both macros sample on posedge clk; CHK_RST is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CHK_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define CHK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CHK_RST(lbl, prop, msg)

`define CHK_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ hw/rtl/tsm_pkg.sv @@
// ---------------------------------------------------------------------------
// tsm_pkg
// Operation and status codes of the thread scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package tsm_pkg;

	typedef logic [2:0] op_t;
	typedef logic [1:0] status_t;

	// operation codes
	localparam op_t OP_SPAWN  = 3'd0;
	localparam op_t OP_YIELD  = 3'd1;
	localparam op_t OP_LOCK   = 3'd2;
	localparam op_t OP_UNLOCK = 3'd3;
	localparam op_t OP_FINISH = 3'd4;

	// result status codes
	localparam status_t ST_OK          = 2'd0;
	localparam status_t ST_NO_FREE     = 2'd1;
	localparam status_t ST_READY_EMPTY = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/thread_scheduler_with_mutexes_core.sv @@
// ---------------------------------------------------------------------------
// thread_scheduler_with_mutexes_core: free list, ready queue, mutex queues.
// Path: an input beat goes through the input reg, then the result reg.
// Throughput: one beat per cycle while out_stall is low; each op does one link read and at most one write.
// Reset: async, free list 0..THREADS-1, initial thread running, mutexes free.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module thread_scheduler_with_mutexes_core
	import tsm_pkg::*;
#(
	parameter int THREADS = 4,
	parameter int MUTEXES = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input channel
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [2:0] operation,
	input  wire logic [1:0] mutex_index,
	// result channel
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [2:0] running_thread,
	output      logic [1:0] spawned_thread,
	output      logic [1:0] status,
	output      logic       mutex_held
);

	localparam int IDS  = THREADS + 1;
	localparam int ID_W = $clog2(THREADS + 2);
	localparam int IX_W = $clog2(IDS);
	localparam int MI_W = (MUTEXES > 1) ? $clog2(MUTEXES) : 1;
	localparam logic [ID_W-1:0] NIL_ID  = ID_W'(THREADS + 1);
	localparam logic [ID_W-1:0] INIT_ID = ID_W'(THREADS);
	localparam logic [ID_W-1:0] IDS_ID  = ID_W'(IDS);

	// scheduler state
	logic [ID_W-1:0]    link_q [IDS];
	logic [ID_W-1:0]    free_head_q, free_tail_q;
	logic [ID_W-1:0]    ready_head_q, ready_tail_q;
	logic [ID_W-1:0]    running_q;
	logic [MUTEXES-1:0] held_q;
	logic [ID_W-1:0]    wait_head_q [MUTEXES];
	logic [ID_W-1:0]    wait_tail_q [MUTEXES];

	// next state
	logic [ID_W-1:0]    free_head_n, free_tail_n;
	logic [ID_W-1:0]    ready_head_n, ready_tail_n;
	logic [ID_W-1:0]    running_n;
	logic [MUTEXES-1:0] held_n;
	logic [ID_W-1:0]    wait_head_n [MUTEXES];
	logic [ID_W-1:0]    wait_tail_n [MUTEXES];

	// input register
	logic            vld_s1;
	op_t             op_s1;
	logic [1:0]      mi_s1;

	// result register
	logic            out_valid_q;
	logic [2:0]      res_running_q;
	logic [1:0]      res_spawned_q;
	status_t         res_status_q;
	logic            res_held_q;

	// link port and per-op results
	logic            lnk_we;
	logic [ID_W-1:0] lnk_wa, lnk_wd, rd_addr, lnk_rd;
	logic [ID_W-1:0] spawn_id;
	status_t         status_n;
	logic            mok;
	logic [MI_W-1:0] m;
	logic            ready_empty, free_empty, wait_empty;
	logic            adv;
	logic            spawn_ok;

	// handshake: the input register moves on when the result register is empty or not stalled
	assign adv       = vld_s1 & (~out_valid_q | ~out_stall);
	assign in_stall  = vld_s1 & out_valid_q & out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= operation;
			mi_s1 <= mutex_index;
		end
	end

	// mutex select and queue status
	assign mok         = (32'(mi_s1) < MUTEXES);
	assign m           = mok ? MI_W'(mi_s1) : '0;
	assign ready_empty = (ready_head_q >= IDS_ID);
	assign free_empty  = (free_head_q >= IDS_ID);
	assign wait_empty  = (wait_head_q[m] >= IDS_ID);

	// single link read port
	assign lnk_rd = (rd_addr < IDS_ID) ? link_q[rd_addr[IX_W-1:0]] : NIL_ID;

	// operation decode and list update
	always_comb begin
		free_head_n  = free_head_q;
		free_tail_n  = free_tail_q;
		ready_head_n = ready_head_q;
		ready_tail_n = ready_tail_q;
		running_n    = running_q;
		held_n       = held_q;
		wait_head_n  = wait_head_q;
		wait_tail_n  = wait_tail_q;
		lnk_we       = 1'b0;
		lnk_wa       = ready_tail_q;
		lnk_wd       = running_q;
		rd_addr      = ready_head_q;
		status_n     = ST_OK;
		spawn_id     = '0;
		case (op_s1)
			OP_SPAWN: begin
				rd_addr = free_head_q;
				if (free_empty) begin
					status_n = ST_NO_FREE;
				end else begin
					spawn_id = free_head_q;
					// pop free list
					if (free_head_q == free_tail_q) begin
						free_head_n = NIL_ID;
						free_tail_n = NIL_ID;
					end else begin
						free_head_n = lnk_rd;
					end
					// append to ready queue
					if (ready_empty) begin
						ready_head_n = free_head_q;
					end else begin
						lnk_we = 1'b1;
						lnk_wa = ready_tail_q;
						lnk_wd = free_head_q;
					end
					ready_tail_n = free_head_q;
				end
			end
			OP_YIELD: begin
				// empty ready queue: the same thread keeps running
				if (!ready_empty) begin
					lnk_we       = 1'b1;
					lnk_wa       = ready_tail_q;
					lnk_wd       = running_q;
					ready_tail_n = running_q;
					running_n    = ready_head_q;
					ready_head_n = (ready_head_q == ready_tail_q) ? running_q : lnk_rd;
				end
			end
			OP_LOCK: begin
				if (mok) begin
					if (!held_q[m]) begin
						held_n[m] = 1'b1;
					end else if (ready_empty) begin
						status_n = ST_READY_EMPTY;
					end else begin
						// running thread waits on the mutex
						if (wait_empty) begin
							wait_head_n[m] = running_q;
						end else begin
							lnk_we = 1'b1;
							lnk_wa = wait_tail_q[m];
							lnk_wd = running_q;
						end
						wait_tail_n[m] = running_q;
						// next ready thread runs
						running_n = ready_head_q;
						if (ready_head_q == ready_tail_q) begin
							ready_head_n = NIL_ID;
							ready_tail_n = NIL_ID;
						end else begin
							ready_head_n = lnk_rd;
						end
					end
				end
			end
			OP_UNLOCK: begin
				rd_addr = wait_head_q[m];
				if (mok) begin
					if (!wait_empty) begin
						// hand the mutex to the oldest waiter
						if (ready_empty) begin
							ready_head_n = running_q;
						end else begin
							lnk_we = 1'b1;
							lnk_wa = ready_tail_q;
							lnk_wd = running_q;
						end
						ready_tail_n = running_q;
						running_n    = wait_head_q[m];
						if (wait_head_q[m] == wait_tail_q[m]) begin
							wait_head_n[m] = NIL_ID;
							wait_tail_n[m] = NIL_ID;
						end else begin
							wait_head_n[m] = lnk_rd;
						end
					end else begin
						held_n[m] = 1'b0;
					end
				end
			end
			OP_FINISH: begin
				if (ready_empty) begin
					status_n = ST_READY_EMPTY;
				end else begin
					running_n = ready_head_q;
					if (ready_head_q == ready_tail_q) begin
						ready_head_n = NIL_ID;
						ready_tail_n = NIL_ID;
					end else begin
						ready_head_n = lnk_rd;
					end
					// initial thread has no slot to return
					if (running_q < INIT_ID) begin
						if (free_empty) begin
							free_head_n = running_q;
						end else begin
							lnk_we = 1'b1;
							lnk_wa = free_tail_q;
							lnk_wd = running_q;
						end
						free_tail_n = running_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < IDS; i++) begin
				link_q[i] <= (i + 1 < THREADS) ? ID_W'(i + 1) : NIL_ID;
			end
			free_head_q  <= '0;
			free_tail_q  <= ID_W'(THREADS - 1);
			ready_head_q <= NIL_ID;
			ready_tail_q <= NIL_ID;
			running_q    <= INIT_ID;
			held_q       <= '0;
			for (int j = 0; j < MUTEXES; j++) begin
				wait_head_q[j] <= NIL_ID;
				wait_tail_q[j] <= NIL_ID;
			end
		end else if (adv) begin
			if (lnk_we) begin
				link_q[lnk_wa[IX_W-1:0]] <= lnk_wd;
			end
			free_head_q  <= free_head_n;
			free_tail_q  <= free_tail_n;
			ready_head_q <= ready_head_n;
			ready_tail_q <= ready_tail_n;
			running_q    <= running_n;
			held_q       <= held_n;
			wait_head_q  <= wait_head_n;
			wait_tail_q  <= wait_tail_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_running_q <= 3'(running_n);
			res_spawned_q <= 2'(spawn_id);
			res_status_q  <= status_n;
			res_held_q    <= mok & held_n[m];
		end
	end

	assign running_thread = res_running_q;
	assign spawned_thread = res_spawned_q;
	assign status         = res_status_q;
	assign mutex_held     = res_held_q;

	// checks
	assign spawn_ok = adv && op_s1 == OP_SPAWN && status_n == ST_OK;

	`CHK_RST(a_running_valid, running_q < IDS_ID, "running thread id is null")
	`CHK_RST(a_ready_ends, (ready_head_q == NIL_ID) == (ready_tail_q == NIL_ID), "ready ends")
	`CHK_RST(a_spawn_moves_free, spawn_ok |=> free_head_q != $past(free_head_q), "free list stuck")
	`CHK_ALWAYS(a_stall_when_full, in_stall |-> vld_s1 && out_valid_q, "stall with room")

	for (genvar g = 0; g < MUTEXES; g++) begin : g_wait_chk
		`CHK_RST(a_wait_needs_held, !held_q[g] |-> wait_head_q[g] == NIL_ID, "waiters on a free mutex")
	end

endmodule

`default_nettype wire
